// File: rtl/uks_pkg.sv
// ----------------------------------------------------------------------------
// uks_pkg: shared definitions for the unique key stack
// Sizes, operation and status codes, and the item types of both channels.
// ----------------------------------------------------------------------------
package uks_pkg;

  // Number of key and value pairs the stack can hold.
  localparam int unsigned STACK_DEPTH = 16;
  // Address bits of one stack entry.
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  // Bits of the fill count, which must also hold STACK_DEPTH itself.
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned DEPTH_W     = 5;

  // Operation codes; the fourth code does nothing.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  // One request item.
  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [VAL_W-1:0] entry_value;
  } uks_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] top_key;
    logic signed [VAL_W-1:0] top_value;
    logic [DEPTH_W-1:0]      depth_now;
    logic                    is_empty;
  } uks_out_t;

endpackage

// File: rtl/uks_ram.sv
// ----------------------------------------------------------------------------
// uks_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module uks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/unique_key_stack.sv
// ----------------------------------------------------------------------------
// unique_key_stack: last-in-first-out store of key and value pairs
// Push, pop and peek with a duplicate key check on every push.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i, in_stall_o, in_data_i) takes one item
//   at a time; each item gives exactly one result item on the result
//   channel (out_valid_o, out_stall_i, out_data_o).
//   A push scans every held key in the key RAM, one read per cycle, and then
//   passes through a drain state to the final state; a push into an empty
//   stack goes straight to the final state. After the result is issued the
//   block returns to idle, where the next item is accepted. Pop, peek and the
//   unused code go straight from acceptance to the final state. The key RAM
//   read port is shared by the scan and the top-of-stack read.
//   A finished result waits in the output register while the next item is
//   accepted and worked on; if the receiver stalls and the following result
//   is ready, the block holds it (and its store update) until the output
//   register frees.
//   Reset clears the fill count and all handshake state; the RAM contents
//   are not cleared, as entries at or above the fill count are never read.
// ----------------------------------------------------------------------------
module unique_key_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uks_pkg::uks_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uks_pkg::uks_out_t out_data_o
);

  import uks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic              hit_q, hit_d;
  uks_in_t           req_q, req_d;
  uks_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_acc;
  logic              out_free;
  logic              is_read_op;
  logic              key_match;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] raddr;
  logic              re;
  logic              we;
  logic [KEY_W-1:0]  key_rdata;
  logic [VAL_W-1:0]  val_rdata;
  uks_out_t          res;
  logic [CNT_W-1:0]  res_fill;
  logic              res_we;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_read_op = (in_data_i.op == OP_POP) || (in_data_i.op == OP_PEEK);
  assign top_addr   = ADDR_W'(fill_q - CNT_W'(1));
  assign key_match  = rd_pend_q && (key_rdata == req_q.entry_key);

  // Read port: the scan walks the entries, otherwise the top entry is read.
  assign raddr = (state_q == S_SCAN) ? idx_q : top_addr;
  assign re    = (state_q == S_SCAN) ||
                 (in_acc && is_read_op && (fill_q != '0));

  // Result of the held request, formed in the final state.
  always_comb begin
    res           = '0;
    res.status    = ST_OK;
    res_fill      = fill_q;
    res_we        = 1'b0;
    case (req_q.op)
      OP_PUSH: begin
        if (hit_q) begin
          res.status = ST_DUP;
        end else if (fill_q == CNT_W'(STACK_DEPTH)) begin
          res.status = ST_OVER;
        end else begin
          res_we   = 1'b1;
          res_fill = fill_q + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (fill_q == '0) begin
          res.status = ST_UNDER;
        end else begin
          res.top_key   = key_rdata;
          res.top_value = val_rdata;
          if (req_q.op == OP_POP) begin
            res_fill = fill_q - CNT_W'(1);
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.depth_now = DEPTH_W'(res_fill);
    res.is_empty  = (res_fill == '0);
  end

  assign we = (state_q == S_FIN) && out_free && res_we;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    rd_pend_d   = (state_q == S_SCAN);
    hit_d       = hit_q || key_match;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        hit_d = 1'b0;
        if (in_acc) begin
          req_d = in_data_i;
          idx_d = '0;
          if ((in_data_i.op == OP_PUSH) && (fill_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        idx_d = idx_q + ADDR_W'(1);
        if ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_d       = res;
          out_valid_d = 1'b1;
          fill_d      = res_fill;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  // Key and value stores.
  uks_ram #(
    .WIDTH(KEY_W),
    .DEPTH(STACK_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(req_q.entry_key),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(key_rdata)
  );

  uks_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(req_q.entry_value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(val_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/uks_chk.sv
// ----------------------------------------------------------------------------
// uks_chk: port-level checks for the unique key stack
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
module uks_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input uks_pkg::uks_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input uks_pkg::uks_out_t out_data_o
);

  import uks_pkg::*;

  // The block works on one item at a time, so it is busy after taking one.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request accepted while the previous one is still in work");

  // The empty flag agrees with the reported depth.
  a_empty_flag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.depth_now == '0))
  ) else $error("empty flag disagrees with depth");

  // An underflow is only reported on an empty stack and returns no pair.
  a_underflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_UNDER)) |->
      (out_data_o.is_empty && (out_data_o.top_key == '0) &&
       (out_data_o.top_value == '0))
  ) else $error("underflow reported with pairs held or a pair returned");

  // An overflow is only reported on a full stack.
  a_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_OVER)) |->
      (out_data_o.depth_now == DEPTH_W'(STACK_DEPTH))
  ) else $error("overflow reported on a stack that is not full");

  // A stalled result item holds its payload.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o))
  ) else $error("stalled result item changed or vanished");

endmodule

bind unique_key_stack uks_chk u_uks_chk (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the unique key stack
// A behavioural copy of the stack predicts one result item for every request
// item accepted. Each result leaving the block is compared field by field
// with the oldest prediction. Directed tests cover the empty stack, extreme
// keys and values, and a full stack. Random phases with push-heavy,
// balanced and pop-heavy traffic follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uks_pkg::*;

  // The fourth operation code, which leaves the stack alone.
  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         TAIL_CYCLES = 4 * (STACK_DEPTH + 3);
  localparam int         POOL_SIZE   = 8;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  uks_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  uks_out_t out_data;

  // Mirror of the stack contents.
  logic signed [KEY_W-1:0] stack_keys [STACK_DEPTH];
  logic signed [VAL_W-1:0] stack_vals [STACK_DEPTH];
  int unsigned             stack_fill = 0;

  uks_out_t                expected_results [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  // When set, that side of the block never idles.
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;

  unique_key_stack DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("unique_key_stack: mismatch");
      $finish;
    end
  end

  // Work out the result of one request and update the mirror.
  function automatic uks_out_t predict_result(uks_in_t req);
    uks_out_t res;
    bit       held;
    res = '0;
    res.status = ST_OK;
    held = 1'b0;
    case (req.op)
      OP_PUSH: begin
        // The duplicate search comes before the full check.
        for (int i = 0; i < int'(stack_fill); i++) begin
          if (stack_keys[i] == req.entry_key) held = 1'b1;
        end
        if (held) begin
          res.status = ST_DUP;
        end else if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_keys[stack_fill] = req.entry_key;
          stack_vals[stack_fill] = req.entry_value;
          stack_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_fill == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.top_key   = stack_keys[stack_fill-1];
          res.top_value = stack_vals[stack_fill-1];
          if (req.op == OP_POP) stack_fill--;
        end
      end
      default: begin
      end
    endcase
    res.depth_now = DEPTH_W'(stack_fill);
    res.is_empty  = (stack_fill == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request item and record its prediction once accepted.
  task automatic send_item(uks_in_t req);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_result(req));
  endtask

  task automatic send_op(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    uks_in_t req;
    req.op          = op;
    req.entry_key   = key;
    req.entry_value = val;
    send_item(req);
  endtask

  // Hold off the request channel until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Result side: idle at random, then take and check one item.
  initial begin
    int       stall_cycles;
    uks_out_t want;
    // The result valid is undefined until the reset has been applied.
    wait (rst_n === 1'b1);
    forever begin
      stall_cycles = rx_calm ? 0 : $urandom_range(0, 3);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_results.size() == 0) begin
        report_mismatch("result item with no request pending", out_data.top_key, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.top_key !== want.top_key)
          report_mismatch("top_key", out_data.top_key, want.top_key);
        if (out_data.top_value !== want.top_value)
          report_mismatch("top_value", out_data.top_value, want.top_value);
        if (out_data.depth_now !== want.depth_now)
          report_mismatch("depth_now", out_data.depth_now, want.depth_now);
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_data.is_empty, want.is_empty);
      end
    end
  end

  // Pop, peek and the unused code on a stack that holds nothing.
  task automatic test_empty_stack();
    send_op(OP_POP, 32'h0, 32'h0);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_NONE, 32'h1234_5678, 32'h9ABC_DEF0);
    drain_results();
  endtask

  // Extreme keys and values, a duplicate of the bottom key, then empty it.
  task automatic test_key_extremes();
    send_op(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_PUSH, 32'h8000_0000, 32'h0);
    send_op(OP_PEEK, 32'h0, 32'h0);
    send_op(OP_POP, 32'h0, 32'h0);
    send_op(OP_POP, 32'h0, 32'h0);
    drain_results();
  endtask

  // Fill the stack, then a duplicate key, a new key, the unused code and a peek on the full stack.
  task automatic test_full_stack();
    logic [KEY_W-1:0] key;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      key = (i % 2 == 0) ? (32'hA5A5_A500 | i) : ~(32'hA5A5_A500 | i);
      send_op(OP_PUSH, key, ~key);
    end
    send_op(OP_PUSH, 32'hA5A5_A500, 32'h0);
    send_op(OP_PUSH, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(OP_NONE, 32'h0, 32'h0);
    send_op(OP_PEEK, 32'h0, 32'h0);
    drain_results();
  endtask

  // Random traffic; keys often come from a small pool to force duplicates.
  task automatic test_random_traffic(int push_pct, int count);
    uks_in_t req;
    int      roll;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 3)
        req.op = OP_NONE;
      else if (roll < push_pct)
        req.op = OP_PUSH;
      else
        req.op = ($urandom_range(2, 0) == 0) ? OP_PEEK : OP_POP;
      req.entry_key   = $urandom_range(1, 0) ? key_pool[$urandom_range(POOL_SIZE-1, 0)]
                                              : $urandom;
      req.entry_value = $urandom;
      send_item(req);
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_stack();
    test_key_extremes();
    test_full_stack();

    // Random phases with changing pressure and idling on either side.
    test_random_traffic(30, 150);
    rx_calm = 1'b1;
    test_random_traffic(85, 200);
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    test_random_traffic(50, 200);
    tx_calm = 1'b0;
    test_random_traffic(15, 150);
    rx_calm = 1'b1;
    tx_calm = 1'b1;
    test_random_traffic(70, 150);
    rx_calm = 1'b0;
    tx_calm = 1'b0;
    test_random_traffic(50, 150);

    // Let any stray result item show up before deciding.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("unique_key_stack: match");
    end else begin
      $display("unique_key_stack: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/uks_pkg.sv
rtl/uks_ram.sv
rtl/unique_key_stack.sv
rtl/uks_chk.sv
tb/sv/tb.sv
